/* design/windowed_peak_volume_leveler_defines.svh */
// Assertion macros of the leveler, used by wpvl_ctrl.
// No dependencies; included by the files that hold assertions.
`ifndef WINDOWED_PEAK_VOLUME_LEVELER_DEFINES_SVH
`define WINDOWED_PEAK_VOLUME_LEVELER_DEFINES_SVH

// Plain property under clock and synchronous reset.
`define WPVL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("wpvl assertion failed");

// Antecedent in this cycle implies consequent in the next.
`define WPVL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wpvl assertion failed");

`endif

/* design/wpvl_pkg.sv */
// Shared types and constants of the windowed peak volume leveler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wpvl_pkg;

   localparam int WIN_LEN   = 100;
   localparam int IDX_W     = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
   localparam int LEVEL_W   = 18;
   localparam int STEP_W    = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_THR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_THR  = 2'd2;

   localparam logic [LEVEL_W-1:0] HIGH_THR_RESET = 18'd8000;
   localparam logic [LEVEL_W-1:0] LOW_THR_RESET  = 18'd4000;

   localparam logic signed [STEP_W-1:0] STEP_NONE = 4'sd0;
   localparam logic signed [STEP_W-1:0] STEP_UP   = -4'sd1;
   localparam logic signed [STEP_W-1:0] STEP_DOWN = 4'sd1;
   localparam logic signed [STEP_W-1:0] STEP_DOWN4 = 4'sd4;

   typedef struct packed {
      logic accept;    // request taken: write ring, latch fields, clear peak
      logic scan;      // read one ring entry, advance scan index
      logic load_out;  // load decision into output register
   } wpvl_cmd_type;

   typedef struct packed {
      logic idx_last;  // scan index is on the last entry
      logic out_free;  // output register empty or emptying now
   } wpvl_status_type;

endpackage

/* design/wpvl_dpath.sv */
// Datapath of the leveler: config registers, level ring, peak scan, output register.
// Depends on wpvl_pkg; driven by wpvl_ctrl through command/status structs.
`timescale 1ns / 1ps

module wpvl_dpath
   import wpvl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [LEVEL_W-1:0]       csr_data,
   input  logic [LEVEL_W-1:0]       req_level,
   input  logic                     req_muted,
   input  wpvl_cmd_type             cmd,
   output wpvl_status_type          status,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic signed [STEP_W-1:0] rsp_step
);

   logic                      enable_ff;
   logic [LEVEL_W-1:0]        high_thr_ff;
   logic [LEVEL_W-1:0]        low_thr_ff;

   logic [LEVEL_W-1:0]        mem [WIN_LEN];
   logic [WIN_LEN-1:0]        valid_ff;
   logic [IDX_W-1:0]          wr_pos_ff;
   logic [IDX_W-1:0]          wr_pos_in;
   logic [IDX_W-1:0]          scan_idx_ff;

   logic [LEVEL_W-1:0]        rd_data_ff;
   logic                      rd_ok_ff;
   logic                      pipe_ff;
   logic [LEVEL_W-1:0]        rd_level;

   logic [LEVEL_W-1:0]        cur_ff;
   logic                      muted_ff;
   logic [LEVEL_W-1:0]        peak_ff;

   logic                      rsp_tvalid_ff;
   logic signed [STEP_W-1:0]  step_ff;
   logic signed [STEP_W-1:0]  step_in;
   logic [LEVEL_W:0]          high_thr_x2;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         high_thr_ff <= HIGH_THR_RESET;
         low_thr_ff  <= LOW_THR_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ENABLE:   enable_ff   <= csr_data[0];
            REG_HIGH_THR: high_thr_ff <= csr_data;
            REG_LOW_THR:  low_thr_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign wr_pos_in = (wr_pos_ff == IDX_W'(WIN_LEN - 1)) ? '0 : wr_pos_ff + 1'b1;

   // ring write position and entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         valid_ff  <= '0;
      end else if (cmd.accept) begin
         wr_pos_ff            <= wr_pos_in;
         valid_ff[wr_pos_ff]  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[wr_pos_ff] <= req_level;
      end
      rd_data_ff <= mem[scan_idx_ff];
   end

   // scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         pipe_ff     <= 1'b0;
         rd_ok_ff    <= 1'b0;
      end else begin
         pipe_ff  <= cmd.scan;
         rd_ok_ff <= valid_ff[scan_idx_ff];
         if (cmd.accept) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
      end
   end

   // unwritten entries read as zero
   assign rd_level = rd_ok_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_ff   <= req_level;
         muted_ff <= req_muted;
         peak_ff  <= '0;
      end else if (pipe_ff && (rd_level > peak_ff)) begin
         peak_ff <= rd_level;
      end
   end

   assign high_thr_x2 = {high_thr_ff, 1'b0};

   always_comb begin
      if (peak_ff < low_thr_ff) begin
         step_in = STEP_UP;
      end else if ({1'b0, cur_ff} > high_thr_x2) begin
         step_in = STEP_DOWN4;
      end else if (cur_ff > high_thr_ff) begin
         step_in = STEP_DOWN;
      end else begin
         step_in = STEP_NONE;
      end
      if (!enable_ff || muted_ff) begin
         step_in = STEP_NONE;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         step_ff <= step_in;
      end
   end

   assign status.idx_last = (scan_idx_ff == IDX_W'(WIN_LEN - 1));
   assign status.out_free = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_tvalid_ff;
   assign rsp_step        = step_ff;

endmodule

/* design/wpvl_ctrl.sv */
// Controller state machine of the leveler: sequences accept, ring scan and result load.
// Depends on wpvl_pkg and windowed_peak_volume_leveler_defines.svh.
`timescale 1ns / 1ps
`include "windowed_peak_volume_leveler_defines.svh"

module wpvl_ctrl
   import wpvl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  wpvl_status_type status,
   output wpvl_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      tready_ff;
   logic      tready_in;

   always_comb begin
      cmd.accept   = req_tvalid && tready_ff;
      cmd.scan     = (state_ff == ST_SCAN);
      cmd.load_out = (state_ff == ST_RESULT) && status.out_free;
      state_in     = state_ff;
      tready_in    = tready_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in  = ST_SCAN;
               tready_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (status.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               state_in  = ST_IDLE;
               tready_in = 1'b1;
            end
         end
         default: begin
            state_in  = ST_IDLE;
            tready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tready_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         tready_ff <= tready_in;
      end
   end

   assign req_tready = tready_ff;

   `WPVL_ASSERT(a_ready_only_idle, clock, reset, !tready_ff || (state_ff == ST_IDLE))
   `WPVL_ASSERT_NEXT(a_accept_starts_scan, clock, reset, cmd.accept, state_ff == ST_SCAN && !tready_ff)
   `WPVL_ASSERT_NEXT(a_scan_end_drains, clock, reset, (state_ff == ST_SCAN) && status.idx_last, state_ff == ST_DRAIN)
   `WPVL_ASSERT_NEXT(a_load_frees_input, clock, reset, cmd.load_out, tready_ff && (state_ff == ST_IDLE))

endmodule

/* design/windowed_peak_volume_leveler.sv */
// Top level of the windowed peak volume leveler: controller plus datapath.
// Depends on wpvl_pkg, wpvl_ctrl and wpvl_dpath.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  req_     | in        | req_tvalid/req_tready | tdata: level[17:0]; tuser: muted
//  rsp_     | out       | rsp_tvalid/rsp_tready | tdata: volume_step[3:0] (signed)
//  csr_     | in        | csr_valid/csr_ready   | csr_index[1:0], csr_data[17:0]
//
//  Each request passes through accept and ring write, a sequential peak scan of
//  the 100-entry ring over the single memory read port, a drain of the registered
//  read, and the load of the result.
//  Reset is synchronous, active high; the ring's entry valid bits clear at once,
//  so there is no clearing pass and the first request is taken right after reset.
//  A result waits in the output register; a new request is taken meanwhile, and
//  its result is held back only if the previous one has still not been taken.
//  csr_ready is tied high; the user writes config while the block is idle, unchecked.

module windowed_peak_volume_leveler
   import wpvl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // [17:0] level, [23:18] zero
   input  logic                 req_tuser,   // [0] muted
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [3:0] volume_step, [7:4] zero
   // config write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEVEL_W-1:0]   csr_data
);

   wpvl_cmd_type             cmd;
   wpvl_status_type          status;
   logic signed [STEP_W-1:0] rsp_step;

   // config is always taken
   assign csr_ready = 1'b1;

   wpvl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wpvl_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_level  (req_tdata[LEVEL_W-1:0]),
      .req_muted  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_step   (rsp_step)
   );

   // step is two's complement in the low nibble, upper bits zero filled
   assign rsp_tdata = {4'b0000, rsp_step};

endmodule

/* dv/tb.sv */
// Self-checking bench for the windowed peak volume leveler: directed table, then random polls.
// Depends on wpvl_pkg and the windowed_peak_volume_leveler top level.
`timescale 1ns / 1ps

module tb
   import wpvl_pkg::*;
();

   localparam int LEVEL_MAX       = 2**LEVEL_W - 1;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int N_PHASES        = 6;
   localparam int N_ROWS          = 27;
   localparam int BLOCK_CYCLES    = WIN_LEN + 3;   // accept, scan, drain, load
   localparam int CYCLE_LIMIT     = 1_000_000;

   // index 3 is not decoded by the block; a write there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata = '0;   // [17:0] level, [23:18] zero
   logic                 req_tuser = 1'b0; // [0] muted
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;        // [3:0] volume_step, [7:4] zero
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LEVEL_W-1:0]   csr_data = '0;

   windowed_peak_volume_leveler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Mirror of the block: level ring, write pointer and the three registers.
   // ---------------------------------------------------------------------------------
   logic [LEVEL_W-1:0] lvl_ring [WIN_LEN];
   logic [IDX_W-1:0]   ring_pos    = '0;
   logic               cfg_enable  = 1'b0;
   logic [LEVEL_W-1:0] cfg_high    = HIGH_THR_RESET;
   logic [LEVEL_W-1:0] cfg_low     = LOW_THR_RESET;

   logic signed [STEP_W-1:0] pending_steps [$];   // one per accepted request, oldest first

   int mismatch_count = 0;
   int results_seen   = 0;
   int cycle_count    = 0;

   // idling: percentage per cycle, plus an occasional long hold
   int tx_pct = 37;
   int rx_pct = 49;
   int tx_hold = 0;
   int rx_hold = 0;

   // Writes the level into the ring, advances the pointer, then decides on the new peak.
   function automatic logic signed [STEP_W-1:0] predict_step(input logic [LEVEL_W-1:0] lvl,
                                                            input logic mute);
      logic [LEVEL_W-1:0]       peak;
      logic [LEVEL_W:0]         twice_high;
      logic signed [STEP_W-1:0] step;
      lvl_ring[ring_pos] = lvl;
      ring_pos = (ring_pos == IDX_W'(WIN_LEN - 1)) ? '0 : ring_pos + 1'b1;
      peak = '0;
      for (int i = 0; i < WIN_LEN; i++)
         if (lvl_ring[i] > peak) peak = lvl_ring[i];
      twice_high = {cfg_high, 1'b0};   // 19 bits, cannot wrap
      if (peak < cfg_low)
         step = STEP_UP;
      else if ({1'b0, lvl} > twice_high)
         step = STEP_DOWN4;
      else if (lvl > cfg_high)
         step = STEP_DOWN;
      else
         step = STEP_NONE;
      if (!cfg_enable || mute) step = STEP_NONE;
      return step;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at result %0d: %s, got %0d, expected %0d",
               results_seen, what, got, want);
      mismatch_count++;
   endtask

   // One request: idle as the current mode says, then hold valid until taken.
   // Valid is left high on return so a back-to-back request never toggles it.
   task automatic send_poll(input logic [LEVEL_W-1:0] lvl, input logic mute,
                            input logic fixed, input logic signed [STEP_W-1:0] fixed_step);
      logic signed [STEP_W-1:0] predicted;
      csr_valid <= 1'b0;
      while (1) begin
         if (tx_hold > 0)
            tx_hold--;
         else if ($urandom_range(0, 99) < tx_pct) begin
            if ($urandom_range(0, 255) == 0) tx_hold = $urandom_range(10, 120);
         end else
            break;
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, lvl};
      req_tuser  <= mute;
      do @(posedge clock); while (!req_tready);
      predicted = predict_step(lvl, mute);
      pending_steps.push_back(fixed ? fixed_step : predicted);
   endtask

   // Register write, only once every outstanding result has come back.
   // Each request gives exactly one result, so an empty queue means the block is idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
      req_tvalid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ENABLE:   cfg_enable = val[0];   // upper data bits ignored
         REG_HIGH_THR: cfg_high   = val;
         REG_LOW_THR:  cfg_low    = val;
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------------------
   // Directed table. Steps typed in where they follow straight from the thresholds;
   // rows with fixed = 0 take the mirror's answer.
   // ---------------------------------------------------------------------------------
   typedef enum logic {ROW_POLL, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_IDX_W-1:0]     idx;     // CSR rows only
      logic [LEVEL_W-1:0]       value;   // level or register data
      logic                     muted;
      logic                     fixed;
      logic signed [STEP_W-1:0] step;
   } stim_row_type;

   stim_row_type directed_rows [N_ROWS] = '{
      // out of reset the block is disabled
      '{ROW_POLL, REG_ENABLE,   18'd0,      1'b0, 1'b1, STEP_NONE},
      // enable with a stray upper bit: only bit 0 counts
      '{ROW_CSR,  REG_ENABLE,   18'd3,      1'b0, 1'b0, STEP_NONE},
      '{ROW_POLL, REG_ENABLE,   18'd0,      1'b0, 1'b1, STEP_UP},
      '{ROW_POLL, REG_ENABLE,   18'd3999,   1'b0, 1'b1, STEP_UP},
      '{ROW_POLL, REG_ENABLE,   18'd3999,   1'b1, 1'b1, STEP_NONE},
      // peak equal to the low threshold: no raise
      '{ROW_POLL, REG_ENABLE,   18'd4000,   1'b0, 1'b1, STEP_NONE},
      // equal to high threshold is not above it
      '{ROW_POLL, REG_ENABLE,   18'd8000,   1'b0, 1'b1, STEP_NONE},
      '{ROW_POLL, REG_ENABLE,   18'd8001,   1'b0, 1'b1, STEP_DOWN},
      '{ROW_POLL, REG_ENABLE,   18'd16000,  1'b0, 1'b1, STEP_DOWN},
      '{ROW_POLL, REG_ENABLE,   18'd16001,  1'b0, 1'b1, STEP_DOWN4},
      '{ROW_POLL, REG_ENABLE,   18'd262143, 1'b0, 1'b1, STEP_DOWN4},
      '{ROW_POLL, REG_ENABLE,   18'd262143, 1'b1, 1'b1, STEP_NONE},
      // undecoded index: must leave enable alone
      '{ROW_CSR,  REG_UNUSED,   18'd0,      1'b0, 1'b0, STEP_NONE},
      '{ROW_POLL, REG_ENABLE,   18'd10000,  1'b0, 1'b0, STEP_NONE},
      // twice this threshold needs the 19th bit
      '{ROW_CSR,  REG_HIGH_THR, 18'd131072, 1'b0, 1'b0, STEP_NONE},
      '{ROW_POLL, REG_ENABLE,   18'd262143, 1'b0, 1'b1, STEP_DOWN},
      '{ROW_CSR,  REG_HIGH_THR, 18'd262143, 1'b0, 1'b0, STEP_NONE},
      '{ROW_POLL, REG_ENABLE,   18'd262143, 1'b0, 1'b1, STEP_NONE},
      '{ROW_CSR,  REG_HIGH_THR, 18'd0,      1'b0, 1'b0, STEP_NONE},
      '{ROW_POLL, REG_ENABLE,   18'd0,      1'b0, 1'b1, STEP_NONE},
      '{ROW_POLL, REG_ENABLE,   18'd1,      1'b0, 1'b1, STEP_DOWN4},
      '{ROW_CSR,  REG_LOW_THR,  18'd262143, 1'b0, 1'b0, STEP_NONE},
      '{ROW_POLL, REG_ENABLE,   18'd5,      1'b0, 1'b0, STEP_NONE},
      '{ROW_CSR,  REG_LOW_THR,  18'd0,      1'b0, 1'b0, STEP_NONE},
      '{ROW_POLL, REG_ENABLE,   18'd0,      1'b0, 1'b0, STEP_NONE},
      '{ROW_CSR,  REG_ENABLE,   18'd0,      1'b0, 1'b0, STEP_NONE},
      '{ROW_POLL, REG_ENABLE,   18'd20000,  1'b0, 1'b1, STEP_NONE}
   };

   // ---------------------------------------------------------------------------------
   // Result side: random back-pressure and in-order checking against the queue.
   // ---------------------------------------------------------------------------------
   logic signed [STEP_W-1:0] want_step;
   logic                     rx_idle;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_steps.size() == 0) begin
               report_mismatch("result with no request outstanding",
                               int'($signed(rsp_tdata[STEP_W-1:0])), 0);
            end else begin
               want_step = pending_steps.pop_front();
               if ($signed(rsp_tdata[STEP_W-1:0]) !== want_step)
                  report_mismatch("volume_step", int'($signed(rsp_tdata[STEP_W-1:0])),
                                  int'(want_step));
               if (rsp_tdata[7:STEP_W] !== '0)
                  report_mismatch("tdata padding", int'(rsp_tdata[7:STEP_W]), 0);
            end
            results_seen++;
         end
         rx_idle = 1'b0;
         if (rx_hold > 0) begin
            rx_hold--;
            rx_idle = 1'b1;
         end else if ($urandom_range(0, 99) < rx_pct) begin
            rx_idle = 1'b1;
            // now and then a long stall, so a result sits while the next one is built
            if ($urandom_range(0, 255) == 0) rx_hold = $urandom_range(10, 120);
         end
         rsp_tready <= !rx_idle;
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------
   logic [LEVEL_W-1:0] lvl;
   logic               mute;
   logic               quiet    = 1'b0;   // quiet scene: levels under the low threshold
   int                 run_left = 0;
   int                 r, span, hi, lo;
   logic               en;

   initial begin
      for (int i = 0; i < WIN_LEN; i++) lvl_ring[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_reg(directed_rows[i].idx, directed_rows[i].value);
         else
            send_poll(directed_rows[i].value, directed_rows[i].muted,
                      directed_rows[i].fixed, directed_rows[i].step);
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph / 2)
            0:       begin tx_pct = 37; rx_pct = 49; end
            1:       begin tx_pct = 49; rx_pct = 37; end
            default: begin tx_pct = 0;  rx_pct = 0;  tx_hold = 0; rx_hold = 0; end
         endcase

         // register settings per phase; the extremes get a phase each
         hi = $urandom_range(500, 40000);
         lo = $urandom_range(0, hi);
         en = 1'b1;
         case (ph)
            0: begin hi = int'(HIGH_THR_RESET); lo = int'(LOW_THR_RESET); end
            2: begin hi = LEVEL_MAX; lo = LEVEL_MAX; end
            3: en = 1'b0;
            4: begin hi = 0; lo = 0; end
            5: write_reg(REG_UNUSED, LEVEL_W'($urandom));
            default: ;
         endcase
         write_reg(REG_ENABLE, {(LEVEL_W-1)'($urandom), en});
         write_reg(REG_HIGH_THR, LEVEL_W'(hi));
         write_reg(REG_LOW_THR, LEVEL_W'(lo));

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // alternate quiet and loud scenes; a quiet scene must outlast the
            // window before the peak drops and raise requests appear
            if (run_left == 0) begin
               quiet    = !quiet;
               run_left = quiet ? $urandom_range(110, 260) : $urandom_range(5, 60);
            end
            run_left--;
            r = $urandom_range(0, 999);
            if (quiet) begin
               if (r < 5)
                  lvl = LEVEL_W'($urandom);     // rare spike that breaks the quiet run
               else
                  lvl = (lo == 0) ? '0 : LEVEL_W'($urandom_range(0, lo - 1));
            end else if (r < 100) begin
               lvl = LEVEL_W'($urandom);
            end else if (r < 160) begin
               // right at the decision boundaries
               case ($urandom_range(0, 5))
                  0:       span = hi;
                  1:       span = hi + 1;
                  2:       span = 2 * hi;
                  3:       span = 2 * hi + 1;
                  4:       span = (lo == 0) ? 0 : lo - 1;
                  default: span = lo;
               endcase
               lvl = LEVEL_W'((span > LEVEL_MAX) ? LEVEL_MAX : span);
            end else begin
               span = 3 * hi + 3;
               lvl  = LEVEL_W'($urandom_range(0, (span > LEVEL_MAX) ? LEVEL_MAX : span));
            end
            mute = ($urandom_range(0, 9) == 0);
            send_poll(lvl, mute, 1'b0, STEP_NONE);
         end
      end

      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      // then wait on, to catch any stray result
      repeat (2 * BLOCK_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/wpvl_pkg.sv
design/wpvl_dpath.sv
design/wpvl_ctrl.sv
design/windowed_peak_volume_leveler.sv
dv/tb.sv
